FILE: design/lphi_pkg.sv
// ============================================================================
// lphi_pkg
// Shared types and constants for the linear probing hash insert block:
// field widths, operation codes and the controller/datapath interface.
// ============================================================================
`default_nettype none

package lphi_pkg;

    // Fixed field widths
    localparam int KEY_W    = 14;
    localparam int SLOT_W   = 5;
    localparam int TSIZE_W  = 6;
    localparam int DCNT_W   = $clog2(KEY_W);

    // Table size after reset
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(32);

    // Operation codes
    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } lphi_op_t;

    // Commands from controller to datapath
    typedef struct packed
    {
        logic load;        // capture input item, clamp table size
        logic div_step;    // one restoring division step of key by size
        logic probe_init;  // start probing at the home slot
        logic probe_adv;   // move to the next slot, wrapping
        logic ins_commit;  // store key in the current slot, load result
        logic rd_home;     // memory read address is the home slot
        logic out_full;    // load full result
        logic out_read;    // load slot read result
    } lphi_cmd_t;

    // Status from datapath to controller
    typedef struct packed
    {
        logic div_done;    // current division step is the last
        logic slot_empty;  // current probe slot is free
        logic probe_last;  // current probe is the last one allowed
        logic out_free;    // output register can take a result this cycle
    } lphi_stat_t;

endpackage : lphi_pkg

`default_nettype wire

FILE: design/lphi_ram.sv
// ============================================================================
// lphi_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module lphi_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule : lphi_ram

`default_nettype wire

FILE: design/lphi_datapath.sv
// ============================================================================
// lphi_datapath
// Key store, occupied marks, bit-serial modulo, probe pointer and the
// result register of the linear probing hash insert block.
// ============================================================================
`default_nettype none

module lphi_datapath #(
    parameter int SLOTS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [lphi_pkg::TSIZE_W-1:0]   cfg_wr_data,
    // input item
    input  wire logic [lphi_pkg::KEY_W-1:0]     key,
    input  wire logic [lphi_pkg::SLOT_W-1:0]    slot,
    // result
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [lphi_pkg::SLOT_W-1:0]    where,
    output logic      [lphi_pkg::KEY_W-1:0]     stored_key,
    output logic                                occupied,
    output logic                                full_res,
    // control
    input  wire lphi_pkg::lphi_cmd_t            cmd,
    output lphi_pkg::lphi_stat_t                stat
);

    import lphi_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int NW = (SW + 1 > TSIZE_W) ? SW + 1 : TSIZE_W;
    localparam logic [NW-1:0] N_MAX = NW'(SLOTS);
    localparam logic [NW-1:0] N_ONE = NW'(1);

    // Registers
    logic [TSIZE_W-1:0] ts_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic               out_valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_sh_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      rem_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic [SW-1:0]      home_reg;
    logic [SW-1:0]      idx_reg;
    logic [NW-1:0]      tries_reg;
    logic [SLOT_W-1:0]  where_reg;
    logic [KEY_W-1:0]   skey_reg;
    logic               occ_reg;
    logic               full_reg;

    // Combinational values
    logic [NW-1:0]      ts_ext;
    logic [NW-1:0]      n_next;
    logic [NW:0]        div_shift;
    logic [NW:0]        n_ext;
    logic [NW-1:0]      rem_next;
    logic [NW-1:0]      idx_inc;
    logic [SW-1:0]      idx_next;
    logic [NW-1:0]      slot_ext;
    logic [SW-1:0]      slot_idx;
    logic               slot_ok;
    logic               read_hit;
    logic [SW-1:0]      rd_addr;
    logic [KEY_W-1:0]   rd_data;
    logic               out_free;
    logic               out_load;
    logic [NW-1:0]      idx_ext;
    logic [NW-1:0]      home_ext;

    // Clamp table size to 1..SLOTS
    always_comb
    begin
        ts_ext = NW'(ts_reg);
        if (ts_reg == '0)
        begin
            n_next = N_ONE;
        end
        else if (ts_ext > N_MAX)
        begin
            n_next = N_MAX;
        end
        else
        begin
            n_next = ts_ext;
        end
    end

    // Restoring division step: bring in the next key bit, subtract if it fits
    assign div_shift = {rem_reg, key_sh_reg[KEY_W-1]};
    assign n_ext     = {1'b0, n_reg};
    assign rem_next  = (div_shift >= n_ext) ? NW'(div_shift - n_ext) : NW'(div_shift);

    // Probe pointer advance with wrap at the table size
    assign idx_ext  = NW'(idx_reg);
    assign home_ext = NW'(home_reg);
    assign idx_inc  = idx_ext + N_ONE;
    assign idx_next = (idx_inc >= n_reg) ? '0 : idx_inc[SW-1:0];

    // Read slot decode
    assign slot_ext = NW'(slot_reg);
    assign slot_idx = slot_ext[SW-1:0];
    assign slot_ok  = (slot_ext < N_MAX);
    assign read_hit = slot_ok && valid_reg[slot_idx];

    // Key store
    assign rd_addr = cmd.rd_home ? home_reg : slot_idx;

    lphi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.ins_commit),
        .waddr (idx_reg),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Output handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = cmd.ins_commit || cmd.out_full || cmd.out_read;

    // Control state: table size, occupied marks, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= TSIZE_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ts_reg <= cfg_wr_data;
            end
            if (cmd.ins_commit)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg     <= key;
            key_sh_reg  <= key;
            slot_reg    <= slot;
            n_reg       <= n_next;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            key_sh_reg  <= {key_sh_reg[KEY_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
        if (cmd.probe_init)
        begin
            home_reg  <= rem_reg[SW-1:0];
            idx_reg   <= rem_reg[SW-1:0];
            tries_reg <= '0;
        end
        if (cmd.probe_adv)
        begin
            idx_reg   <= idx_next;
            tries_reg <= tries_reg + N_ONE;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.ins_commit)
        begin
            where_reg <= idx_ext[SLOT_W-1:0];
            skey_reg  <= key_reg;
            occ_reg   <= 1'b1;
            full_reg  <= 1'b0;
        end
        else if (cmd.out_full)
        begin
            where_reg <= home_ext[SLOT_W-1:0];
            skey_reg  <= rd_data;
            occ_reg   <= 1'b1;
            full_reg  <= 1'b1;
        end
        else if (cmd.out_read)
        begin
            where_reg <= slot_reg;
            skey_reg  <= read_hit ? rd_data : '0;
            occ_reg   <= read_hit;
            full_reg  <= 1'b0;
        end
    end

    // Status to controller
    assign stat.div_done   = (div_cnt_reg == DCNT_W'(KEY_W - 1));
    assign stat.slot_empty = !valid_reg[idx_reg];
    assign stat.probe_last = (tries_reg == n_reg - N_ONE);
    assign stat.out_free   = out_free;

    assign out_valid  = out_valid_reg;
    assign where      = where_reg;
    assign stored_key = skey_reg;
    assign occupied   = occ_reg;
    assign full_res   = full_reg;

endmodule : lphi_datapath

`default_nettype wire

FILE: design/lphi_ctrl.sv
// ============================================================================
// lphi_ctrl
// Sequencer for the linear probing hash insert block: accepts one item,
// steps the modulo, the probe and the memory reads, and hands over results.
// ============================================================================
`default_nettype none

module lphi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 op,
    output lphi_pkg::lphi_cmd_t       cmd,
    input  wire lphi_pkg::lphi_stat_t stat
);

    import lphi_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIVIDE,
        ST_SETUP,
        ST_PROBE,
        ST_FULL_WAIT,
        ST_FULL_OUT,
        ST_RD_WAIT,
        ST_RD_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (lphi_op_t'(op) == OP_READ) ? ST_RD_WAIT : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.probe_init = 1'b1;
                state_next     = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (stat.slot_empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.ins_commit = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (stat.probe_last)
                begin
                    state_next = ST_FULL_WAIT;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                end
            end
            ST_FULL_WAIT:
            begin
                cmd.rd_home = 1'b1;
                state_next  = ST_FULL_OUT;
            end
            ST_FULL_OUT:
            begin
                cmd.rd_home = 1'b1;
                if (stat.out_free)
                begin
                    cmd.out_full = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        in_stall_next = (state_next != ST_IDLE);
    end

    // Hold state and the registered input stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule : lphi_ctrl

`default_nettype wire

FILE: design/linear_probe_hash_insert_top.sv
// ============================================================================
// linear_probe_hash_insert_top
// Hash table with linear probing: inserts keys at key modulo table size,
// probing upward to the first free slot, and reads single slots back.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                  | Transfer when
//  ---------+------------------------------------------+------------------------
//  in       | in_valid, in_stall, op, key, slot        | in_valid & !in_stall
//  out      | out_valid, out_stall, where, stored_key, | out_valid & !out_stall
//           | occupied, full_res                       |
//  cfg      | cfg_wr_en, cfg_wr_data (table_size)      | cfg_wr_en
//
//  Insert: accept, bit-serial modulo over the key bits, setup, then one probe
//  per cycle over the occupied-mark flops (held while a free slot waits on
//  the output register), up to table size probes; a full table adds a wait
//  and an output state for the key memory read. Read: accept, wait and output
//  states around the registered key memory read. One item is in work at a
//  time; in_stall is high until its result is in the output register, which a
//  stalled receiver holds. Reset clears all occupied marks; no clearing pass.
// ============================================================================
`default_nettype none

module linear_probe_hash_insert_top #(
    parameter int SLOTS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [lphi_pkg::TSIZE_W-1:0]   cfg_wr_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           op,
    input  wire logic [lphi_pkg::KEY_W-1:0]     key,
    input  wire logic [lphi_pkg::SLOT_W-1:0]    slot,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [lphi_pkg::SLOT_W-1:0]    where,
    output logic      [lphi_pkg::KEY_W-1:0]     stored_key,
    output logic                                occupied,
    output logic                                full_res
);

    import lphi_pkg::*;

    lphi_cmd_t  cmd;
    lphi_stat_t stat;

    // Sequencer
    lphi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Table, modulo and result datapath
    lphi_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .key         (key),
        .slot        (slot),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .where       (where),
        .stored_key  (stored_key),
        .occupied    (occupied),
        .full_res    (full_res),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule : linear_probe_hash_insert_top

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear probing hash insert block. A shadow copy
// of the slot table predicts each result; directed rows cover the corners and
// random phases at different table sizes exercise probing, wrap and full-table
// reporting under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lphi_pkg::*;

    localparam int SLOTS = 32;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 78;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS = 40;

    typedef struct packed
    {
        logic [SLOT_W-1:0] where;
        logic [KEY_W-1:0]  stored_key;
        logic              occupied;
        logic              full_res;
    } slot_report_t;

    typedef struct packed
    {
        logic               is_cfg;
        logic [TSIZE_W-1:0] size_val;
        lphi_op_t           op;
        logic [KEY_W-1:0]   key;
        logic [SLOT_W-1:0]  slot;
        logic               typed;
        slot_report_t       want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [TSIZE_W-1:0] cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
    logic               out_valid;
    logic               out_stall;
    logic [SLOT_W-1:0]  where;
    logic [KEY_W-1:0]   stored_key;
    logic               occupied;
    logic               full_res;

    // Shadow of the block's table and size register
    logic [KEY_W-1:0]   shadow_keys [SLOTS];
    logic               shadow_used [SLOTS];
    logic [TSIZE_W-1:0] shadow_size;

    slot_report_t awaited_reports [$];
    stim_row_t    directed_rows [$];
    slot_report_t due;
    int           mismatch_count;
    logic         hold_request;

    linear_probe_hash_insert_top #(
        .SLOTS(SLOTS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .key        (key),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .where      (where),
        .stored_key (stored_key),
        .occupied   (occupied),
        .full_res   (full_res)
    );

    // Clock, 8 ns period
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Apply one item to the shadow table and return the result it should give
    function automatic slot_report_t hash_table_apply(input lphi_op_t o,
                                                      input logic [KEY_W-1:0] k,
                                                      input logic [SLOT_W-1:0] s);
        slot_report_t res;
        int n;
        int home;
        int idx;
        res = '0;
        if (o == OP_READ)
        begin
            res.where = s;
            if (shadow_used[s])
            begin
                res.stored_key = shadow_keys[s];
                res.occupied = 1'b1;
            end
            return res;
        end
        n = (shadow_size == 0) ? 1 : ((shadow_size > SLOTS) ? SLOTS : int'(shadow_size));
        home = int'(k) % n;
        idx = home;
        for (int t = 0; t < n; t++)
        begin
            if (!shadow_used[idx])
            begin
                shadow_used[idx] = 1'b1;
                shadow_keys[idx] = k;
                res.where = idx[SLOT_W-1:0];
                res.stored_key = k;
                res.occupied = 1'b1;
                return res;
            end
            idx = (idx + 1 >= n) ? 0 : idx + 1;
        end
        // every slot in use is taken: report the home slot as it stands
        res.where = home[SLOT_W-1:0];
        res.stored_key = shadow_keys[home];
        res.occupied = 1'b1;
        res.full_res = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_v);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want_v);
    endtask

    task automatic add_item(input lphi_op_t o, input int k, input int s);
        directed_rows.push_back('{1'b0, '0, o, KEY_W'(k), SLOT_W'(s), 1'b0, '0});
    endtask

    task automatic add_checked(input lphi_op_t o, input int k, input int s,
                               input int w, input int sk, input bit occ, input bit full);
        slot_report_t r;
        r = '{SLOT_W'(w), KEY_W'(sk), occ, full};
        directed_rows.push_back('{1'b0, '0, o, KEY_W'(k), SLOT_W'(s), 1'b1, r});
    endtask

    task automatic add_size(input int v);
        directed_rows.push_back('{1'b1, TSIZE_W'(v), OP_INSERT, '0, '0, 1'b0, '0});
    endtask

    // Offer one item and hold it until the block takes the transfer
    task automatic send_item(input lphi_op_t o, input logic [KEY_W-1:0] k,
                             input logic [SLOT_W-1:0] s);
        @(negedge clk);
        in_valid = 1'b1;
        op = o;
        key = k;
        slot = s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // Drop valid and wait until every awaited result has arrived
    task automatic drain_table();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_table_size(input logic [TSIZE_W-1:0] v);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        shadow_size = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_reports.size() == 0)
                report_mismatch("unexpected result, where", int'(where), -1);
            else
            begin
                due = awaited_reports.pop_front();
                if (where !== due.where)
                    report_mismatch("where", int'(where), int'(due.where));
                if (stored_key !== due.stored_key)
                    report_mismatch("stored_key", int'(stored_key), int'(due.stored_key));
                if (occupied !== due.occupied)
                    report_mismatch("occupied", int'(occupied), int'(due.occupied));
                if (full_res !== due.full_res)
                    report_mismatch("full_res", int'(full_res), int'(due.full_res));
            end
        end
    end

    // Receiver: stall in modes of random length, with long hold-offs on request
    initial
    begin
        int mode;
        int left_in_mode;
        int hold_left;
        out_stall = 1'b0;
        mode = 0;
        left_in_mode = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (left_in_mode == 0)
            begin
                mode = $urandom_range(0, 3);
                left_in_mode = $urandom_range(20, 150);
            end
            left_in_mode--;
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    2: out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = ~out_stall;
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t r;
        slot_report_t pred;
        lphi_op_t o;
        logic [KEY_W-1:0] k;
        logic [SLOT_W-1:0] s;
        int phase_size [PHASES];
        int n_left;
        int burst;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        op = OP_INSERT;
        key = '0;
        slot = '0;
        hold_request = 1'b0;
        mismatch_count = 0;
        shadow_size = TSIZE_RESET;
        foreach (shadow_used[i])
        begin
            shadow_used[i] = 1'b0;
            shadow_keys[i] = '0;
        end

        // empty table after reset, extremes of key, collision and wrap
        add_checked(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0);
        add_checked(OP_READ, 16383, 31, 31, 0, 1'b0, 1'b0);
        add_checked(OP_INSERT, 0, 0, 0, 0, 1'b1, 1'b0);
        add_checked(OP_INSERT, 16383, 31, 31, 16383, 1'b1, 1'b0);
        add_item(OP_INSERT, 9999, 0);
        add_item(OP_INSERT, 32, 0);
        add_item(OP_INSERT, 63, 0);
        add_item(OP_READ, 0, 2);
        add_item(OP_READ, 0, 31);
        // size zero acts as one slot: table already full
        add_size(0);
        add_checked(OP_INSERT, 5, 31, 0, 0, 1'b1, 1'b1);
        // slots beyond the table size still read back as they are
        add_item(OP_READ, 0, 3);
        add_item(OP_READ, 0, 15);
        // size above the slot count is clamped
        add_size(63);
        add_item(OP_INSERT, 12345, 0);
        // shrink after inserts: fill the last free slot, then overflow
        add_size(4);
        add_item(OP_INSERT, 7, 0);
        add_checked(OP_INSERT, 4, 0, 0, 0, 1'b1, 1'b1);
        add_item(OP_INSERT, 6, 0);
        add_size(40);
        add_item(OP_INSERT, 9999, 0);
        add_item(OP_READ, 0, 25);

        phase_size = '{2, 5, 9, 0, 16, 24, 63, 1, 12, 33, 28, 32};
        phase_size[10] = $urandom_range(0, 63);

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.is_cfg)
            begin
                drain_table();
                write_table_size(r.size_val);
            end
            else
            begin
                send_item(r.op, r.key, r.slot);
                pred = hash_table_apply(r.op, r.key, r.slot);
                awaited_reports.push_back(r.typed ? r.want : pred);
            end
        end

        // Random phases, one table size each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_table();
            write_table_size(TSIZE_W'(phase_size[ph]));
            n_left = PHASE_ITEMS;
            while (n_left > 0)
            begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && n_left > 0)
                begin
                    o = ($urandom_range(0, 9) < 4) ? OP_READ : OP_INSERT;
                    if ($urandom_range(0, 7) == 0)
                        k = KEY_W'($urandom_range(10000, 16383));
                    else
                        k = KEY_W'($urandom_range(0, 9999));
                    s = SLOT_W'($urandom_range(0, SLOTS - 1));
                    send_item(o, k, s);
                    awaited_reports.push_back(hash_table_apply(o, k, s));
                    burst--;
                    n_left--;
                    // hold the receiver off while items keep coming
                    if (ph % 4 == 2 && n_left == 40)
                        hold_request = 1'b1;
                end
                pause_sender((ph % 4 == 1) ? 0 : $urandom_range(0, 10));
            end
        end

        drain_table();
        repeat (60)
            @(posedge clk);
        if (awaited_reports.size() != 0)
            report_mismatch("results left over", awaited_reports.size(), 0);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
